// ===== hw/rtl/bsef_pkg.sv =====
`timescale 1ns / 1ps
package bsef_pkg;

  localparam int unsigned Lanes = 8;
  localparam int unsigned Layers = 6;
  localparam int unsigned PairsPerLayer = 4;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t value_7;
    word_t value_6;
    word_t value_5;
    word_t value_4;
    word_t value_3;
    word_t value_2;
    word_t value_1;
    word_t value_0;
  } in_beat_t;

  typedef struct packed {
    word_t sorted_7;
    word_t sorted_6;
    word_t sorted_5;
    word_t sorted_4;
    word_t sorted_3;
    word_t sorted_2;
    word_t sorted_1;
    word_t sorted_0;
  } out_beat_t;

  typedef word_t [Lanes-1:0] vec_t;

  typedef logic [2:0] lane_idx_t;

  // per layer, per compare-exchange: {index that gets the larger, index that gets the smaller}
  typedef lane_idx_t [1:0] pair_t;
  typedef pair_t [PairsPerLayer-1:0] layer_t;

  localparam layer_t NetPairs [Layers] = '{
    '{pair_t'{3'd6, 3'd7}, pair_t'{3'd2, 3'd3}, pair_t'{3'd5, 3'd4}, pair_t'{3'd1, 3'd0}},
    '{pair_t'{3'd5, 3'd7}, pair_t'{3'd4, 3'd6}, pair_t'{3'd3, 3'd1}, pair_t'{3'd2, 3'd0}},
    '{pair_t'{3'd6, 3'd7}, pair_t'{3'd4, 3'd5}, pair_t'{3'd3, 3'd2}, pair_t'{3'd1, 3'd0}},
    '{pair_t'{3'd7, 3'd3}, pair_t'{3'd6, 3'd2}, pair_t'{3'd5, 3'd1}, pair_t'{3'd4, 3'd0}},
    '{pair_t'{3'd7, 3'd5}, pair_t'{3'd6, 3'd4}, pair_t'{3'd3, 3'd1}, pair_t'{3'd2, 3'd0}},
    '{pair_t'{3'd7, 3'd6}, pair_t'{3'd5, 3'd4}, pair_t'{3'd3, 3'd2}, pair_t'{3'd1, 3'd0}}
  };

  function automatic logic is_nan(input word_t v);
    return v[30:0] > 31'h7F80_0000;
  endfunction

  function automatic word_t order_key(input word_t v);
    return v[31] ? ~v : {1'b1, v[30:0]};
  endfunction

  // ieee ordered a < b
  function automatic logic f32_less(input word_t a, input word_t b);
    logic res;
    res = order_key(a) < order_key(b);
    if (is_nan(a) || is_nan(b)) res = 1'b0;
    if ((a[30:0] | b[30:0]) == 31'd0) res = 1'b0;
    return res;
  endfunction

endpackage

// ===== hw/rtl/bitonic_sort_eight_floats.sv =====
`timescale 1ns / 1ps
// eight-float bitonic sorter, ascending by ieee value
// in channel: in_valid_i / in_stall_o carry one beat of eight raw single words
// out channel: out_valid_o / out_stall_i carry one beat of eight sorted words
// a beat is taken on a clock edge with valid high and stall low
// six compare-exchange layers, one register stage each
// an accepted beat passes the six layer registers in order before out_valid_o rises
// throughput: one beat per cycle while the receiver does not stall
// equal values (incl. -0/+0) and any pair with a nan are not swapped
// on out_stall_i a full stage holds only if all later ones are full; in_stall_o
// rises only when the last stage holds a stalled beat, so bubbles still fill
// reset clears all stage valid bits; no beat is in flight afterwards
module bitonic_sort_eight_floats (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bsef_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bsef_pkg::out_beat_t out_data_o
);

  bsef_pkg::vec_t vec   [bsef_pkg::Layers+1];
  logic           valid [bsef_pkg::Layers+1];
  logic           en    [bsef_pkg::Layers];

  assign vec[0]   = bsef_pkg::vec_t'(in_data_i);
  assign valid[0] = in_valid_i;

  // a stage advances when downstream advances or it is empty downstream
  assign en[bsef_pkg::Layers-1] = !(valid[bsef_pkg::Layers] && out_stall_i);
  for (genvar g = 0; g < bsef_pkg::Layers-1; g++) begin : g_en
    assign en[g] = en[g+1] || !valid[g+1];
  end

  for (genvar g = 0; g < bsef_pkg::Layers; g++) begin : g_layer
    bsef_layer #(.Layer(g)) u_layer (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[g]),
      .valid_i (valid[g]),
      .vec_i   (vec[g]),
      .valid_o (valid[g+1]),
      .vec_o   (vec[g+1])
    );
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid[bsef_pkg::Layers];
  assign out_data_o  = bsef_pkg::out_beat_t'(vec[bsef_pkg::Layers]);

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");
  a_sorted_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !bsef_pkg::f32_less(out_data_o.sorted_7, out_data_o.sorted_6))
    else $error("top pair out of order");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i |=> valid[1])
    else $error("accepted beat missing in first stage");
`endif

endmodule

// ===== hw/rtl/bsef_layer.sv =====
`timescale 1ns / 1ps
module bsef_layer #(
  parameter int unsigned Layer = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  bsef_pkg::vec_t   vec_i,
  output logic             valid_o,
  output bsef_pkg::vec_t   vec_o
);

  bsef_pkg::vec_t vec_d, vec_q;
  logic           valid_q;

  always_comb begin
    vec_d = vec_i;
    for (int p = 0; p < bsef_pkg::PairsPerLayer; p++) begin
      if (bsef_pkg::f32_less(vec_i[bsef_pkg::NetPairs[Layer][p][1]],
                             vec_i[bsef_pkg::NetPairs[Layer][p][0]])) begin
        vec_d[bsef_pkg::NetPairs[Layer][p][0]] = vec_i[bsef_pkg::NetPairs[Layer][p][1]];
        vec_d[bsef_pkg::NetPairs[Layer][p][1]] = vec_i[bsef_pkg::NetPairs[Layer][p][0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule
